FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold on every rising clock edge outside reset.
`define VMM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");
// Expression must never be true outside reset.
`define VMM_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define VMM_ASSERT(lbl, clk, rst_n, prop)
`define VMM_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: src/vmm_pkg.sv
// Package: constants, types and helpers of the vector-matrix multiply core.
`timescale 1ns / 1ps
`default_nettype none
package vmm_pkg;

  localparam int MAX_DIM = 16;
  localparam int POS_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W   = $clog2(MAX_DIM + 1) + 1;
  localparam int CFG_W   = 5;
  localparam int CIDX_W  = 2;
  localparam int ELEM_W  = 32;
  localparam int ACC_W   = 64;
  localparam int IDX_W   = 4;

  localparam logic [CIDX_W-1:0] REG_MAT_ROWS = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MAT_COLS = 2'd1;
  localparam logic [CIDX_W-1:0] REG_MODE     = 2'd2;

  localparam logic REQ_VECTOR = 1'b0;
  localparam logic REQ_MATRIX = 1'b1;

  localparam logic MODE_ROW_VEC = 1'b0;
  localparam logic MODE_COL_VEC = 1'b1;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_OUT
  } state_t;

  // Zero acts as one, anything above MAX_DIM acts as MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (int'(d) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(d);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/vmm_mac.sv
// Shared multiply-accumulate unit: registered 32x32 product, saturating 64-bit add.
`timescale 1ns / 1ps
`default_nettype none
module vmm_mac
  import vmm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     mul_en,
  input  wire logic signed [ELEM_W-1:0] op_a,
  input  wire logic signed [ELEM_W-1:0] op_b,
  input  wire logic        [ACC_W-1:0]  acc_in,
  output logic             [ACC_W-1:0]  sum
);

  logic signed [ACC_W-1:0] prod_r;
  logic        [ACC_W-1:0] raw;
  logic                    ovf;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= ACC_W'(op_a) * ACC_W'(op_b);
    end
  end

  always_comb begin
    raw = acc_in + ACC_W'(prod_r);
    ovf = (acc_in[ACC_W-1] == prod_r[ACC_W-1]) && (raw[ACC_W-1] != acc_in[ACC_W-1]);
    if (ovf) begin
      sum = acc_in[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end else begin
      sum = raw;
    end
  end

endmodule
`default_nettype wire

FILE: src/vector_matrix_multiply_core.sv
// Top level: vector-matrix multiply core with sequencer, stores and shared MAC.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------
//  input   | in_req_type, in_element_value           | start && !busy
//  result  | out_result_value, out_result_index,     | out_strobe, one cycle
//          | out_last                                |
//  config  | cfg_index, cfg_data                     | cfg_we
//
// A vector item is written straight into the vector store. A matrix item goes
// through the shared multiplier, which registers the product, and then the
// saturating adder, which updates the accumulator. In mode 0 the final matrix
// item is followed by an output pass in which the column accumulators are read
// out one per cycle. Results are registered and are never held off. Reset is
// immediate: no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vector_matrix_multiply_core
  import vmm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     in_req_type,
  input  wire logic signed [ELEM_W-1:0] in_element_value,
  output logic                          out_strobe,
  output logic signed [ACC_W-1:0]       out_result_value,
  output logic        [IDX_W-1:0]       out_result_index,
  output logic                          out_last,
  input  wire logic                     cfg_we,
  input  wire logic   [CIDX_W-1:0]      cfg_index,
  input  wire logic   [CFG_W-1:0]       cfg_data
);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] rows_cfg_r, cols_cfg_r;
  logic             mode_r;
  logic [DIM_W-1:0] rows_c, cols_c, vlen_c;

  logic [ELEM_W-1:0] vec_r [MAX_DIM];
  logic [ACC_W-1:0]  col_acc_r [MAX_DIM];
  logic [ACC_W-1:0]  row_acc_r;

  logic [POS_W-1:0] vec_pos_r, row_pos_r, col_pos_r, out_pos_r;

  logic             accept, vec_acc, mat_acc;
  logic             cfg_hit, clr_work;
  logic             in_acc_st, in_out_st;
  logic             col_last, row_last, vec_last, out_pos_last;
  logic [ELEM_W-1:0] vec_rd;
  logic [ACC_W-1:0]  acc_in, sum;

  logic                   strobe_nxt, last_nxt;
  logic [ACC_W-1:0]       value_nxt;
  logic [IDX_W-1:0]       index_nxt;
  logic                   strobe_r, last_r;
  logic [ACC_W-1:0]       value_r;
  logic [IDX_W-1:0]       index_r;

  assign rows_c = clamp_dim(rows_cfg_r);
  assign cols_c = clamp_dim(cols_cfg_r);
  assign vlen_c = (mode_r == MODE_ROW_VEC) ? rows_c : cols_c;

  assign accept  = start && !busy;
  assign vec_acc = accept && (in_req_type == REQ_VECTOR);
  assign mat_acc = accept && (in_req_type == REQ_MATRIX);
  assign cfg_hit = cfg_we && (cfg_index == REG_MAT_ROWS || cfg_index == REG_MAT_COLS ||
                              cfg_index == REG_MODE);

  assign col_last     = (DIM_W'(col_pos_r) + DIM_W'(1)) == cols_c;
  assign row_last     = (DIM_W'(row_pos_r) + DIM_W'(1)) == rows_c;
  assign vec_last     = (DIM_W'(vec_pos_r) + DIM_W'(1)) == vlen_c;
  assign out_pos_last = (DIM_W'(out_pos_r) + DIM_W'(1)) == cols_c;

  assign vec_rd = vec_r[(mode_r == MODE_ROW_VEC) ? row_pos_r : col_pos_r];
  assign acc_in = (mode_r == MODE_ROW_VEC) ? col_acc_r[col_pos_r] : row_acc_r;

  vmm_mac u_mac (
    .clk    (clk),
    .mul_en (mat_acc),
    .op_a   (vec_rd),
    .op_b   (in_element_value),
    .acc_in (acc_in),
    .sum    (sum)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (mat_acc) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (mode_r == MODE_ROW_VEC && col_last && row_last) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_pos_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state decoded controls
  always_comb begin
    busy      = 1'b1;
    in_acc_st = 1'b0;
    in_out_st = 1'b0;
    case (state_r)
      ST_IDLE: busy      = 1'b0;
      ST_ACC:  in_acc_st = 1'b1;
      ST_OUT:  in_out_st = 1'b1;
      default: busy      = 1'b1;
    endcase
  end

  // clear on config write, on a new vector, and at end of matrix
  always_comb begin
    clr_work = cfg_hit || (vec_acc && vec_pos_r == '0);
    if (in_acc_st && col_last && row_last && mode_r == MODE_COL_VEC) begin
      clr_work = 1'b1;
    end
    if (in_out_st && out_pos_last) begin
      clr_work = 1'b1;
    end
  end

  // result register
  always_comb begin
    strobe_nxt = 1'b0;
    value_nxt  = sum;
    index_nxt  = IDX_W'(row_pos_r);
    last_nxt   = row_last;
    if (in_acc_st && col_last && mode_r == MODE_COL_VEC) begin
      strobe_nxt = 1'b1;
    end
    if (in_out_st) begin
      strobe_nxt = 1'b1;
      value_nxt  = col_acc_r[out_pos_r];
      index_nxt  = IDX_W'(out_pos_r);
      last_nxt   = out_pos_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    index_r <= index_nxt;
    last_r  <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CFG_W'(16);
      cols_cfg_r <= CFG_W'(16);
      mode_r     <= MODE_ROW_VEC;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAT_ROWS: rows_cfg_r <= cfg_data;
        REG_MAT_COLS: cols_cfg_r <= cfg_data;
        REG_MODE:     mode_r     <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (vec_acc) begin
      vec_r[vec_pos_r] <= in_element_value;
    end
  end

  // positions
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      vec_pos_r <= '0;
      row_pos_r <= '0;
      col_pos_r <= '0;
      out_pos_r <= '0;
    end else begin
      if (vec_acc) begin
        vec_pos_r <= vec_last ? '0 : vec_pos_r + POS_W'(1);
        if (vec_pos_r == '0) begin
          row_pos_r <= '0;
          col_pos_r <= '0;
        end
      end
      if (in_acc_st) begin
        col_pos_r <= col_last ? '0 : col_pos_r + POS_W'(1);
        if (col_last) begin
          row_pos_r <= row_last ? '0 : row_pos_r + POS_W'(1);
        end
      end
      if (in_out_st) begin
        out_pos_r <= out_pos_last ? '0 : out_pos_r + POS_W'(1);
      end
    end
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || clr_work) begin
      for (int i = 0; i < MAX_DIM; i++) begin
        col_acc_r[i] <= '0;
      end
      row_acc_r <= '0;
    end else if (in_acc_st) begin
      if (mode_r == MODE_ROW_VEC) begin
        col_acc_r[col_pos_r] <= sum;
      end else begin
        row_acc_r <= col_last ? '0 : sum;
      end
    end
  end

  assign out_strobe       = strobe_r;
  assign out_result_value = value_r;
  assign out_result_index = index_r;
  assign out_last         = last_r;

  `VMM_ASSERT(a_strobe_src, clk, rst_n, out_strobe |-> $past(busy))
  `VMM_ASSERT(a_last_gap, clk, rst_n, (out_strobe && out_last) |=> !out_strobe)
  `VMM_NEVER(a_out_mode, clk, rst_n, in_out_st && mode_r != MODE_ROW_VEC)
  `VMM_NEVER(a_col_range, clk, rst_n, DIM_W'(col_pos_r) >= cols_c)

endmodule
`default_nettype wire
